>>> src/trie_word_counter_defines.svh
`ifndef TRIE_WORD_COUNTER_DEFINES_SVH
`define TRIE_WORD_COUNTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/twc_pkg.sv
`timescale 1ns / 1ps

package twc_pkg;

    // Node pool and trie geometry
    localparam int NODE_COUNT = 4096;
    localparam int NODE_W     = 12;
    localparam int FREE_W     = NODE_W + 1;
    localparam int ALPHA      = 26;
    localparam int ALPHA_W    = $clog2(ALPHA);
    localparam int SLOT_COUNT = NODE_COUNT * ALPHA;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = 32;
    localparam int CHAR_W     = 8;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [FREE_W-1:0]  free_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ALPHA_W-1:0] idx_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         kind_t;

    // Result kinds
    localparam kind_t KIND_WORD = 2'd0;
    localparam kind_t KIND_END  = 2'd1;
    localparam kind_t KIND_FULL = 2'd2;

    // Character codes
    localparam char_t CH_NUL     = 8'd0;
    localparam char_t CH_UPPER_A = 8'd65;
    localparam char_t CH_UPPER_Z = 8'd90;
    localparam char_t CH_LOWER_A = 8'd97;
    localparam char_t CH_LOWER_Z = 8'd122;

    localparam count_t COUNT_MAX    = '1;
    localparam node_t  DISTINCT_MAX = '1;

    typedef struct packed {
        kind_t  kind;
        node_t  node_index;
        count_t word_count;
        node_t  distinct_words;
        logic   last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    // One node: the link slot that points at it, and its word count
    typedef struct packed {
        slot_t  parent;
        count_t count;
    } node_entry_t;

    localparam int NODE_ENTRY_W = $bits(node_entry_t);

    typedef struct packed {
        logic  re;
        slot_t raddr;
        logic  we;
        slot_t waddr;
        node_t wdata;
    } link_req_t;

    typedef struct packed {
        logic        re;
        node_t       raddr;
        logic        we;
        node_t       waddr;
        node_entry_t wdata;
    } node_req_t;

    typedef struct packed {
        logic hit;
        idx_t idx;
    } letter_t;

    // Fold case and map a letter to 0..25
    function automatic letter_t decode_letter(char_t ch);
        letter_t r;
        r.hit = 1'b0;
        r.idx = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            r.hit = 1'b1;
            r.idx = idx_t'(ch - CH_UPPER_A);
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            r.hit = 1'b1;
            r.idx = idx_t'(ch - CH_LOWER_A);
        end
        return r;
    endfunction

    // Link slot of child idx under node n
    function automatic slot_t slot_of(node_t n, idx_t i);
        return slot_t'(slot_t'(n) * slot_t'(ALPHA)) + slot_t'(i);
    endfunction

endpackage

>>> src/twc_text_if.sv
`timescale 1ns / 1ps

interface twc_text_if import twc_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

>>> src/twc_result_if.sv
`timescale 1ns / 1ps

interface twc_result_if import twc_pkg::*; ();
    logic   valid;
    logic   ready;
    kind_t  kind;
    node_t  node_index;
    count_t word_count;
    node_t  distinct_words;
    logic   last;

    modport source (
        output valid, output kind, output node_index, output word_count,
        output distinct_words, output last, input ready
    );
    modport sink (
        input valid, input kind, input node_index, input word_count,
        input distinct_words, input last, output ready
    );
endinterface

>>> src/twc_ram.sv
`timescale 1ns / 1ps

module twc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/twc_out_reg.sv
`timescale 1ns / 1ps

module twc_out_reg import twc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output logic          space,
    twc_result_if.source  result
);

    logic    valid_reg;
    result_t data_reg;

    // Room for a new word when empty or when the held one leaves now
    assign space = !valid_reg || result.ready;

    // Hold the valid flag until the sink takes the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload on push
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            data_reg <= push.res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = data_reg.kind;
    assign result.node_index     = data_reg.node_index;
    assign result.word_count     = data_reg.word_count;
    assign result.distinct_words = data_reg.distinct_words;
    assign result.last           = data_reg.last;

endmodule

>>> src/twc_ctrl.sv
`timescale 1ns / 1ps

module twc_ctrl import twc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    twc_text_if.sink    text,
    output push_t       push,
    input  logic        space,
    output link_req_t   link_req,
    input  node_t       link_rdata,
    output node_req_t   node_req,
    input  node_entry_t node_rdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LINK     = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_FIN_SEP  = 3'd3;
    localparam logic [2:0] S_FIN_END  = 3'd4;
    localparam logic [2:0] S_EMIT_END = 3'd5;

    logic [2:0] state_reg, state_next;
    node_t      cur_reg, cur_next;
    free_t      free_reg, free_next;
    logic       inside_reg, inside_next;
    logic       skip_reg, skip_next;
    node_t      distinct_reg, distinct_next;
    slot_t      slot_reg, slot_next;
    node_t      link_reg, link_next;

    logic    acc;
    logic    pending;
    logic    link_hit;
    logic    pool_full;
    logic    bump;
    count_t  cnt_new;
    letter_t lt;
    slot_t   slot_in;

    assign text.ready = (state_reg == S_IDLE);
    assign acc        = text.valid && text.ready;
    assign lt         = decode_letter(text.character);
    assign slot_in    = slot_of(cur_reg, lt.idx);
    assign pending    = inside_reg && !skip_reg;
    assign pool_full  = (free_reg == free_t'(NODE_COUNT));

    // Saturating count update and distinct-word bump for the word being closed
    assign cnt_new = (node_rdata.count == COUNT_MAX) ? node_rdata.count
                                                     : node_rdata.count + count_t'(1);
    assign bump    = (node_rdata.count == '0) && (distinct_reg != DISTINCT_MAX);

    // A stored link is live only if it points at a node of this text
    // whose recorded parent slot is the one just read
    always_comb
    begin
        link_hit = 1'b0;
        if (link_reg != '0)
        begin
            if (free_t'(link_reg) < free_reg)
            begin
                if (node_rdata.parent == slot_reg)
                begin
                    link_hit = 1'b1;
                end
            end
        end
    end

    // Sequence one word through link read, node read and update
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        inside_next   = inside_reg;
        skip_next     = skip_reg;
        distinct_next = distinct_reg;
        slot_next     = slot_reg;
        link_next     = link_reg;
        link_req      = '0;
        node_req      = '0;
        push          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    priority if (text.character == CH_NUL)
                    begin
                        if (pending)
                        begin
                            node_req.re    = 1'b1;
                            node_req.raddr = cur_reg;
                            state_next     = S_FIN_END;
                        end
                        else
                        begin
                            state_next = S_EMIT_END;
                        end
                    end
                    else if (lt.hit)
                    begin
                        inside_next = 1'b1;
                        if (!skip_reg)
                        begin
                            link_req.re    = 1'b1;
                            link_req.raddr = slot_in;
                            slot_next      = slot_in;
                            state_next     = S_LINK;
                        end
                    end
                    else
                    begin
                        if (pending)
                        begin
                            node_req.re    = 1'b1;
                            node_req.raddr = cur_reg;
                            state_next     = S_FIN_SEP;
                        end
                        else
                        begin
                            cur_next    = '0;
                            inside_next = 1'b0;
                            skip_next   = 1'b0;
                        end
                    end
                end
            end

            S_LINK:
            begin
                // Fetch the node the link points at to verify it
                link_next      = link_rdata;
                node_req.re    = 1'b1;
                node_req.raddr = link_rdata;
                state_next     = S_CHECK;
            end

            S_CHECK:
            begin
                priority if (link_hit)
                begin
                    cur_next   = link_reg;
                    state_next = S_IDLE;
                end
                else if (pool_full)
                begin
                    // Flag the full pool and drop the rest of the word
                    if (space)
                    begin
                        push.valid              = 1'b1;
                        push.res.kind           = KIND_FULL;
                        push.res.node_index     = cur_reg;
                        push.res.distinct_words = distinct_reg;
                        push.res.last           = 1'b1;
                        skip_next               = 1'b1;
                        state_next              = S_IDLE;
                    end
                end
                else
                begin
                    // Take the next free node for this child
                    link_req.we           = 1'b1;
                    link_req.waddr        = slot_reg;
                    link_req.wdata        = node_t'(free_reg);
                    node_req.we           = 1'b1;
                    node_req.waddr        = node_t'(free_reg);
                    node_req.wdata.parent = slot_reg;
                    node_req.wdata.count  = '0;
                    cur_next              = node_t'(free_reg);
                    free_next             = free_reg + free_t'(1);
                    state_next            = S_IDLE;
                end
            end

            S_FIN_SEP, S_FIN_END:
            begin
                if (space)
                begin
                    node_req.we             = 1'b1;
                    node_req.waddr          = cur_reg;
                    node_req.wdata.parent   = node_rdata.parent;
                    node_req.wdata.count    = cnt_new;
                    distinct_next           = distinct_reg + node_t'(bump);
                    push.valid              = 1'b1;
                    push.res.kind           = KIND_WORD;
                    push.res.node_index     = cur_reg;
                    push.res.word_count     = cnt_new;
                    push.res.distinct_words = distinct_reg + node_t'(bump);
                    push.res.last           = (state_reg == S_FIN_SEP);
                    cur_next                = '0;
                    inside_next             = 1'b0;
                    skip_next               = 1'b0;
                    state_next              = (state_reg == S_FIN_SEP) ? S_IDLE : S_EMIT_END;
                end
            end

            S_EMIT_END:
            begin
                // Report the text total, then start a fresh trie
                if (space)
                begin
                    push.valid              = 1'b1;
                    push.res.kind           = KIND_END;
                    push.res.distinct_words = distinct_reg;
                    push.res.last           = 1'b1;
                    cur_next                = '0;
                    free_next               = free_t'(1);
                    inside_next             = 1'b0;
                    skip_next               = 1'b0;
                    distinct_next           = '0;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            free_reg     <= free_t'(1);
            inside_reg   <= 1'b0;
            skip_reg     <= 1'b0;
            distinct_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            free_reg     <= free_next;
            inside_reg   <= inside_next;
            skip_reg     <= skip_next;
            distinct_reg <= distinct_next;
        end
    end

    // Hold the slot and link of the letter under way
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        link_reg <= link_next;
    end

endmodule

>>> src/trie_word_counter.sv
`timescale 1ns / 1ps
`include "trie_word_counter_defines.svh"

// Word frequency counter over a byte stream. Letters (either case) walk a trie of
// 4096 nodes with 26 child links each; a separator after a word bumps that word's
// saturating count and returns the word's node and count; a zero byte closes any
// pending word, returns the number of distinct words and starts a new trie. If a
// letter needs a node when the pool is exhausted, a pool-full word is returned and
// the rest of that word is ignored. A letter passes through the child link memory
// read, a read of the node memory to confirm the link belongs to the current text,
// and the decide/allocate step. A separator that closes a word reads the node
// memory, then writes the count back; a zero byte does the same for a pending word
// and then reports the total. A separator with no word, or a letter of an ignored
// word, is handled on acceptance alone. A step that hands on a result waits while
// the output register is still full. The block is ready straight out of reset: each
// node records the link slot that owns it and is initialized when allocated, so stale
// links from earlier texts are recognized and no memory clearing pass exists.
module trie_word_counter import twc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    twc_text_if.sink     text,
    twc_result_if.source result
);

    push_t                   push;
    logic                    space;
    link_req_t               link_req;
    node_req_t               node_req;
    node_t                   link_rdata;
    logic [NODE_ENTRY_W-1:0] node_rdata_raw;
    node_entry_t             node_rdata;

    assign node_rdata = node_entry_t'(node_rdata_raw);

    // Child links, one per node and letter
    twc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    // Per-node owner slot and word count
    twc_ram #(
        .WIDTH (NODE_ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_req.we),
        .waddr (node_req.waddr),
        .wdata (node_req.wdata),
        .re    (node_req.re),
        .raddr (node_req.raddr),
        .rdata (node_rdata_raw)
    );

    twc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push       (push),
        .space      (space),
        .link_req   (link_req),
        .link_rdata (link_rdata),
        .node_req   (node_req),
        .node_rdata (node_rdata)
    );

    twc_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .result (result)
    );

    // Checks
    `TWC_ASSERT_NOW(a_push_space, push.valid, space, "word pushed into full output register")
    `TWC_ASSERT_NOW(a_alloc_pair, link_req.we, node_req.we, "link written without node init")
    `TWC_ASSERT_NOW(a_root_kept, node_req.we, node_req.waddr != '0, "root node entry written")
    `TWC_ASSERT_NOW(a_idle_quiet, text.valid && text.ready, !push.valid, "push while accepting")
    `TWC_ASSERT_NEXT(a_alloc_done, link_req.we, text.ready, "not ready after node allocation")

endmodule
